/* hw/rtl/sevq_pkg.sv */
// Package for the sorted event queue: command and status codes, default sizes,
// and the control and status structs between the controller and the datapath.
// No dependencies.
`timescale 1ns / 1ps

package sevq_pkg;

	localparam int DEF_QUEUE_DEPTH = 64;
	localparam int DEF_KEY_BITS    = 32;
	localparam int FIELD_W         = 32;
	localparam int CMD_W           = 2;
	localparam int STATUS_W        = 2;

	localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
	localparam logic [CMD_W-1:0] CMD_APPEND = 2'd1;
	localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd2;

	localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
	localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
	localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

	// commands from the controller to the datapath
	typedef struct packed {
		logic                capture;   // take the input item, reset scan position
		logic                rd_probe;  // read entry just before the scan position
		logic                shift_wr;  // move the probed entry one slot toward the tail
		logic                place_wr;  // write the new entry at the scan position
		logic                pop_rd;    // read the head entry
		logic                pop_take;  // latch the head entry and drop it
		logic                load_res;  // load the result register
		logic [STATUS_W-1:0] res_status;
	} ctl_t;

	// status from the datapath to the controller
	typedef struct packed {
		logic [CMD_W-1:0] cmd;
		logic             full;
		logic             empty;
		logic             pos_zero;
		logic             key_gt;
		logic             res_free;
	} sts_t;

endpackage

/* hw/rtl/sevq_in_if.sv */
// Channel interfaces of the sorted event queue: command items in, result items out.
// Depends on sevq_pkg.
`timescale 1ns / 1ps

interface sevq_in_if;
	logic                             valid;
	logic                             ready;
	logic [sevq_pkg::CMD_W-1:0]       cmd;
	logic [sevq_pkg::FIELD_W-1:0]     in_key;
	logic [sevq_pkg::FIELD_W-1:0]     in_payload;

	modport source (output valid, output cmd, output in_key, output in_payload, input ready);
	modport sink   (input valid, input cmd, input in_key, input in_payload, output ready);
endinterface

interface sevq_out_if #(parameter int CNT_W = 7);
	logic                             valid;
	logic                             ready;
	logic                             out_valid;
	logic [sevq_pkg::FIELD_W-1:0]     out_key;
	logic [sevq_pkg::FIELD_W-1:0]     out_payload;
	logic [sevq_pkg::STATUS_W-1:0]    status;
	logic [CNT_W-1:0]                 occupancy;

	modport source (output valid, output out_valid, output out_key, output out_payload,
		output status, output occupancy, input ready);
	modport sink   (input valid, input out_valid, input out_key, input out_payload,
		input status, input occupancy, output ready);
endinterface

/* hw/rtl/sevq_ctrl.sv */
// Controller of the sorted event queue: sequences insert scans, appends and pops.
// Depends on sevq_pkg.
`timescale 1ns / 1ps

module sevq_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	input  sevq_pkg::sts_t sts,
	output sevq_pkg::ctl_t ctl
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_DECODE,
		S_PROBE_RD,
		S_PROBE_CMP,
		S_PLACE,
		S_POP_RD,
		S_POP_TAKE,
		S_RESULT
	} state_t;

	state_t                          state_q;
	logic [sevq_pkg::STATUS_W-1:0]   status_q;

	// decode commands from state
	always_comb begin
		ctl            = '0;
		ctl.res_status = status_q;
		in_ready       = (state_q == S_IDLE);
		unique case (state_q)
			S_IDLE:      ctl.capture  = in_valid;
			S_DECODE:    ;
			S_PROBE_RD:  ctl.rd_probe = !sts.pos_zero;
			S_PROBE_CMP: ctl.shift_wr = sts.key_gt;
			S_PLACE:     ctl.place_wr = 1'b1;
			S_POP_RD:    ctl.pop_rd   = 1'b1;
			S_POP_TAKE:  ctl.pop_take = 1'b1;
			S_RESULT:    ctl.load_res = sts.res_free;
			default:     ;
		endcase
	end

	// advance state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			status_q <= sevq_pkg::ST_OK;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) state_q <= S_DECODE;
				end
				S_DECODE: begin
					status_q <= sevq_pkg::ST_OK;
					case (sts.cmd)
						sevq_pkg::CMD_INSERT: begin
							if (sts.full) begin
								status_q <= sevq_pkg::ST_FULL;
								state_q  <= S_RESULT;
							end else begin
								state_q <= S_PROBE_RD;
							end
						end
						sevq_pkg::CMD_APPEND: begin
							if (sts.full) begin
								status_q <= sevq_pkg::ST_FULL;
								state_q  <= S_RESULT;
							end else begin
								state_q <= S_PLACE;
							end
						end
						sevq_pkg::CMD_REMOVE: begin
							if (sts.empty) begin
								status_q <= sevq_pkg::ST_EMPTY;
								state_q  <= S_RESULT;
							end else begin
								state_q <= S_POP_RD;
							end
						end
						default: state_q <= S_RESULT;
					endcase
				end
				S_PROBE_RD: begin
					state_q <= sts.pos_zero ? S_PLACE : S_PROBE_CMP;
				end
				S_PROBE_CMP: begin
					state_q <= sts.key_gt ? S_PROBE_RD : S_PLACE;
				end
				S_PLACE:    state_q <= S_RESULT;
				S_POP_RD:   state_q <= S_POP_TAKE;
				S_POP_TAKE: state_q <= S_RESULT;
				S_RESULT: begin
					if (sts.res_free) state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

/* hw/rtl/sevq_dp.sv */
// Datapath of the sorted event queue: circular entry memory, head and count,
// scan position, and the result register. Depends on sevq_pkg and the interfaces.
`timescale 1ns / 1ps

module sevq_dp #(
	parameter int QUEUE_DEPTH = sevq_pkg::DEF_QUEUE_DEPTH,
	parameter int KEY_BITS    = sevq_pkg::DEF_KEY_BITS,
	parameter int CNT_W       = $clog2(QUEUE_DEPTH + 1)
) (
	input  logic           clk,
	input  logic           arst_n,
	sevq_in_if.sink        req,
	sevq_out_if.source     rsp,
	input  sevq_pkg::ctl_t ctl,
	output sevq_pkg::sts_t sts
);

	localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int FW = sevq_pkg::FIELD_W;

	logic [KEY_BITS-1:0] key_mem [QUEUE_DEPTH];
	logic [FW-1:0]       hdl_mem [QUEUE_DEPTH];

	logic [sevq_pkg::CMD_W-1:0] cmd_q;
	logic [KEY_BITS-1:0]        key_q;
	logic [FW-1:0]              hdl_q;
	logic [CNT_W-1:0]           pos_q;
	logic [CNT_W-1:0]           count_q;
	logic [AW-1:0]              head_q;
	logic [KEY_BITS-1:0]        rd_key_q;
	logic [FW-1:0]              rd_hdl_q;
	logic                       popped_q;
	logic [KEY_BITS-1:0]        pop_key_q;
	logic [FW-1:0]              pop_hdl_q;
	logic                       rsp_full_q;

	logic [AW-1:0] pos_addr;
	logic [AW-1:0] prev_addr;
	logic [AW-1:0] rd_addr;
	logic [AW-1:0] wr_addr;
	logic [AW-1:0] head_next;
	logic          wr_en;

	// map a position counted from the head onto a memory slot
	function automatic logic [AW-1:0] slot_of(input logic [AW-1:0] head,
		input logic [CNT_W-1:0] pos);
		logic [AW:0] sum;
		sum = {1'b0, head} + (AW + 1)'(pos);
		if (sum >= (AW + 1)'(QUEUE_DEPTH)) sum = sum - (AW + 1)'(QUEUE_DEPTH);
		return sum[AW-1:0];
	endfunction

	assign pos_addr  = slot_of(head_q, pos_q);
	assign prev_addr = slot_of(head_q, pos_q - CNT_W'(1));
	assign rd_addr   = ctl.pop_rd ? head_q : prev_addr;
	assign wr_addr   = pos_addr;
	assign wr_en     = ctl.shift_wr || ctl.place_wr;
	assign head_next = (head_q == AW'(QUEUE_DEPTH - 1)) ? '0 : head_q + AW'(1);

	// status toward the controller
	assign sts.cmd      = cmd_q;
	assign sts.full     = (count_q == CNT_W'(QUEUE_DEPTH));
	assign sts.empty    = (count_q == '0);
	assign sts.pos_zero = (pos_q == '0);
	assign sts.key_gt   = (rd_key_q > key_q);
	assign sts.res_free = !rsp_full_q || rsp.ready;

	// entry memory: one write, one registered read
	always_ff @(posedge clk) begin
		if (wr_en) begin
			key_mem[wr_addr] <= ctl.place_wr ? key_q : rd_key_q;
			hdl_mem[wr_addr] <= ctl.place_wr ? hdl_q : rd_hdl_q;
		end
		if (ctl.rd_probe || ctl.pop_rd) begin
			rd_key_q <= key_mem[rd_addr];
			rd_hdl_q <= hdl_mem[rd_addr];
		end
	end

	// hold the accepted item and the popped entry
	always_ff @(posedge clk) begin
		if (ctl.capture) begin
			cmd_q     <= req.cmd;
			key_q     <= KEY_BITS'(req.in_key);
			hdl_q     <= req.in_payload;
			pop_key_q <= '0;
			pop_hdl_q <= '0;
		end else if (ctl.pop_take) begin
			pop_key_q <= rd_key_q;
			pop_hdl_q <= rd_hdl_q;
		end
	end

	// queue bookkeeping
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q  <= '0;
			head_q   <= '0;
			pos_q    <= '0;
			popped_q <= 1'b0;
		end else begin
			if (ctl.capture) begin
				pos_q    <= count_q;
				popped_q <= 1'b0;
			end else if (ctl.shift_wr) begin
				pos_q <= pos_q - CNT_W'(1);
			end
			if (ctl.place_wr) count_q <= count_q + CNT_W'(1);
			if (ctl.pop_take) begin
				count_q  <= count_q - CNT_W'(1);
				head_q   <= head_next;
				popped_q <= 1'b1;
			end
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_full_q <= 1'b0;
		end else if (ctl.load_res) begin
			rsp_full_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_full_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.load_res) begin
			rsp.out_valid   <= popped_q;
			rsp.out_key     <= FW'(pop_key_q);
			rsp.out_payload <= pop_hdl_q;
			rsp.status      <= ctl.res_status;
			rsp.occupancy   <= count_q;
		end
	end

	assign rsp.valid = rsp_full_q;

endmodule

/* hw/rtl/sorted_event_queue_core.sv */
// Top level of the sorted event queue: controller plus datapath.
// Depends on sevq_pkg, sevq_in_if, sevq_out_if, sevq_ctrl and sevq_dp.
//
//   channel | dir | fields                                          | handshake
//   req     | in  | cmd, in_key, in_payload                         | valid/ready
//   rsp     | out | out_valid, out_key, out_payload, status, occupancy | valid/ready
//
// One item at a time. After decode, code 3 and dropped inserts or appends go straight
// to the result state; append places the entry; remove reads the head, then takes it
// (an empty remove goes straight to the result); a sorted insert does one read, then
// compare and shift, per moved entry, and places the entry once the scan stops.
// Reset clears count, head and control; the memory needs no clearing.
// A stalled result holds the block in its result state until taken.
`timescale 1ns / 1ps

module sorted_event_queue_core #(
	parameter int QUEUE_DEPTH = sevq_pkg::DEF_QUEUE_DEPTH,
	parameter int KEY_BITS    = sevq_pkg::DEF_KEY_BITS
) (
	input  logic       clk,
	input  logic       arst_n,
	sevq_in_if.sink    req,
	sevq_out_if.source rsp
);

	sevq_pkg::ctl_t ctl;
	sevq_pkg::sts_t sts;

	sevq_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (req.valid),
		.in_ready (req.ready),
		.sts      (sts),
		.ctl      (ctl)
	);

	sevq_dp #(
		.QUEUE_DEPTH (QUEUE_DEPTH),
		.KEY_BITS    (KEY_BITS),
		.CNT_W       ($clog2(QUEUE_DEPTH + 1))
	) u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rsp    (rsp),
		.ctl    (ctl),
		.sts    (sts)
	);

endmodule

/* bench/testbench.sv */
// Self-checking bench for sorted_event_queue_core: drives command items, predicts results
// with a behavioral model of the sorted queue and checks each result item in order.
// Depends on sevq_pkg, sevq_in_if, sevq_out_if and the RTL top level.
`timescale 1ns / 1ps

module testbench;
	import sevq_pkg::*;

	localparam int DEPTH = DEF_QUEUE_DEPTH;
	localparam int CNT_W = 7;
	localparam int LIMIT = 1500000;

	localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

	typedef struct packed {
		logic [CMD_W-1:0]   cmd;
		logic [FIELD_W-1:0] key;
		logic [FIELD_W-1:0] payload;
	} cmd_item_t;

	typedef struct packed {
		logic                got;
		logic [FIELD_W-1:0] key;
		logic [FIELD_W-1:0] payload;
		logic [STATUS_W-1:0] status;
		logic [CNT_W-1:0]   occupancy;
	} result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	sevq_in_if req ();
	sevq_out_if #(.CNT_W(CNT_W)) rsp ();

	sorted_event_queue_core u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req.sink),
		.rsp    (rsp.source)
	);

	always #5 clk = ~clk;

	// model state of the event list
	logic [FIELD_W-1:0] model_keys[$];
	logic [FIELD_W-1:0] model_handles[$];

	cmd_item_t pending_cmds[$];
	result_t   expected_results[$];
	int        fail_count = 0;
	int        cycle_count = 0;
	bit        stim_done = 0;
	int        hold_off = 0;	// long receiver stall; not used, the monitor sets its own

	function automatic result_t predict_result(cmd_item_t it);
		result_t r;
		int pos;
		r = '0;
		if (it.cmd == CMD_INSERT || it.cmd == CMD_APPEND) begin
			if (model_keys.size() >= DEPTH) begin
				r.status = ST_FULL;
			end else if (it.cmd == CMD_APPEND) begin
				model_keys.push_back(it.key);
				model_handles.push_back(it.payload);
			end else begin
				pos = model_keys.size();
				while (pos > 0 && model_keys[pos-1] > it.key)
					pos--;
				model_keys.insert(pos, it.key);
				model_handles.insert(pos, it.payload);
			end
		end else if (it.cmd == CMD_REMOVE) begin
			if (model_keys.size() == 0) begin
				r.status = ST_EMPTY;
			end else begin
				r.got = 1'b1;
				r.key = model_keys.pop_front();
				r.payload = model_handles.pop_front();
			end
		end
		r.occupancy = CNT_W'(model_keys.size());
		return r;
	endfunction

	function automatic cmd_item_t make_cmd(logic [CMD_W-1:0] c, logic [FIELD_W-1:0] k,
			logic [FIELD_W-1:0] p);
		cmd_item_t it;
		it.cmd = c;
		it.key = k;
		it.payload = p;
		return it;
	endfunction

	// draw a gap after an accepted item; at least a third of items have none
	function automatic int pick_gap();
		return ($urandom_range(0, 2) == 0) ? 0 : int'($urandom_range(0, 11));
	endfunction

	// fill the stimulus queue
	initial begin
		int n;
		int mode;
		logic [FIELD_W-1:0] base;
		// directed: empty remove, extremes, ties, full queue, code 3
		pending_cmds.push_back(make_cmd(CMD_REMOVE, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
		pending_cmds.push_back(make_cmd(CMD_UNUSED, 32'h1234, 32'h5678));
		pending_cmds.push_back(make_cmd(CMD_INSERT, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
		pending_cmds.push_back(make_cmd(CMD_INSERT, 32'h0, 32'h0));
		pending_cmds.push_back(make_cmd(CMD_INSERT, 32'h0, 32'h1));
		pending_cmds.push_back(make_cmd(CMD_INSERT, 32'h8000_0000, 32'hA5A5_A5A5));
		pending_cmds.push_back(make_cmd(CMD_APPEND, 32'h1, 32'h5A5A_5A5A));
		pending_cmds.push_back(make_cmd(CMD_INSERT, 32'h2, 32'h2));
		pending_cmds.push_back(make_cmd(CMD_INSERT, 32'h0, 32'h3));
		for (int i = 0; i < 8; i++)
			pending_cmds.push_back(make_cmd(CMD_REMOVE, $urandom, $urandom));
		pending_cmds.push_back(make_cmd(CMD_REMOVE, 32'h0, 32'h0));
		// fill to full and overflow, then drain
		for (int i = 0; i < DEPTH + 2; i++)
			pending_cmds.push_back(make_cmd(i[0] ? CMD_APPEND : CMD_INSERT,
				$urandom_range(0, 40), $urandom));
		pending_cmds.push_back(make_cmd(CMD_UNUSED, 32'h0, 32'h0));
		for (int i = 0; i < DEPTH + 1; i++)
			pending_cmds.push_back(make_cmd(CMD_REMOVE, 32'h0, 32'h0));
		// random mix, mostly sorted inserts and removes near a moving base time
		n = 0;
		base = 0;
		while (n < 650) begin
			mode = $urandom_range(0, 99);
			base = base + $urandom_range(0, 3);
			if (mode < 40)
				pending_cmds.push_back(make_cmd(CMD_INSERT,
					($urandom_range(0, 9) == 0) ? $urandom : base + $urandom_range(0, 15),
					$urandom));
			else if (mode < 50)
				pending_cmds.push_back(make_cmd(CMD_APPEND,
					($urandom_range(0, 4) == 0) ? $urandom : base + $urandom_range(0, 15),
					$urandom));
			else if (mode < 95)
				pending_cmds.push_back(make_cmd(CMD_REMOVE, $urandom, $urandom));
			else
				pending_cmds.push_back(make_cmd(CMD_UNUSED, $urandom, $urandom));
			n++;
		end
	end

	// reset
	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
	end

	// driver: offer items with random gaps; one NBA per signal per edge
	int  send_gap = 0;
	int  sent = 0;
	always @(posedge clk or negedge arst_n) begin
		int gap;
		gap = 0;
		if (!arst_n) begin
			req.valid      <= 1'b0;
			req.cmd        <= '0;
			req.in_key     <= '0;
			req.in_payload <= '0;
			send_gap       <= 0;
		end else begin
			if (req.valid && req.ready) begin
				expected_results.push_back(predict_result(pending_cmds.pop_front()));
				sent++;
				gap = pick_gap();
			end
			if (req.valid && !req.ready) begin
				// hold the offered item
			end else if (pending_cmds.size() == 0) begin
				req.valid <= 1'b0;
			end else if (send_gap > 0) begin
				req.valid <= 1'b0;
				send_gap  <= send_gap - 1;
			end else if (gap > 0) begin
				req.valid <= 1'b0;
				send_gap  <= gap - 1;
			end else begin
				req.valid      <= 1'b1;
				req.cmd        <= pending_cmds[0].cmd;
				req.in_key     <= pending_cmds[0].key;
				req.in_payload <= pending_cmds[0].payload;
			end
		end
	end

	// monitor: random stall per item, one long stall early on
	int  recv_wait = 0;
	int  received = 0;
	bit  long_done = 0;
	always @(posedge clk or negedge arst_n) begin
		result_t exp_r;
		if (!arst_n) begin
			rsp.ready <= 1'b0;
			recv_wait <= 0;
		end else begin
			if (rsp.valid && rsp.ready) begin
				received++;
				if (expected_results.size() == 0) begin
					$error("result with no expectation waiting");
					fail_count++;
				end else begin
					exp_r = expected_results.pop_front();
					if (rsp.out_valid !== exp_r.got) begin
						$error("out_valid exp %0h got %0h", exp_r.got, rsp.out_valid);
						fail_count++;
					end
					if (rsp.out_key !== exp_r.key) begin
						$error("out_key exp %0h got %0h", exp_r.key, rsp.out_key);
						fail_count++;
					end
					if (rsp.out_payload !== exp_r.payload) begin
						$error("out_payload exp %0h got %0h", exp_r.payload, rsp.out_payload);
						fail_count++;
					end
					if (rsp.status !== exp_r.status) begin
						$error("status exp %0h got %0h", exp_r.status, rsp.status);
						fail_count++;
					end
					if (rsp.occupancy !== exp_r.occupancy) begin
						$error("occupancy exp %0d got %0d", exp_r.occupancy, rsp.occupancy);
						fail_count++;
					end
				end
			end
			if (!long_done && received == 20) begin
				long_done <= 1'b1;
				recv_wait <= 400;
				rsp.ready <= 1'b0;
			end else if (recv_wait > 0) begin
				recv_wait <= recv_wait - 1;
				rsp.ready <= 1'b0;
			end else if (rsp.valid && rsp.ready) begin
				if ($urandom_range(0, 2) == 0) begin
					rsp.ready <= 1'b1;
				end else begin
					recv_wait <= $urandom_range(0, 11);
					rsp.ready <= 1'b0;
				end
			end else begin
				rsp.ready <= 1'b1;
			end
		end
	end

	// cycle limit
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > LIMIT) begin
			$display("status: fail");
			$finish;
		end
	end

	// end of run
	initial begin
		wait (arst_n);
		@(posedge clk);
		wait (pending_cmds.size() == 0 && !req.valid);
		wait (expected_results.size() == 0);
		repeat (200) @(posedge clk);
		if (fail_count == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
